@@ rtl/core/edtt_pkg.sv @@
// Shared constants and codes for the earliest-deadline timer table.
package edtt_pkg;

  localparam int unsigned EDTT_SLOTS     = 32;
  localparam int unsigned EDTT_TAG_BITS  = 16;
  localparam int unsigned EDTT_TIME_BITS = 48;

  localparam int unsigned KIND_W    = 3;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned DELAY_W   = 32;
  // ms -> us scale; 1000 < 2**10, so the product needs 10 extra bits
  localparam int unsigned US_PER_MS = 1000;
  localparam int unsigned SPAN_W    = DELAY_W + 10;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 3'd0,
    KIND_FIRE   = 3'd1,
    KIND_REMOVE = 3'd2,
    KIND_FIND   = 3'd3,
    KIND_QUERY  = 3'd4,
    KIND_CLEAR  = 3'd5
  } edtt_kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_NONE = 2'd1,
    STAT_FULL = 2'd2
  } edtt_status_e;

endpackage

@@ rtl/core/earliest_deadline_timer_table_top.sv @@
// Earliest-deadline one-shot timer table: slot memory, scan and compaction control.
//
//  channel   dir  handshake                   payload (lowest bit up)
//  -------   ---  --------------------------  -------------------------------------
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser: kind; tdata: now_us, delay_ms, tag
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: status, fired_tag, wait_us
//
// Fire, remove, find and query scan every live timer; a fire or remove that hits
// then moves each entry above the hit down one slot. The pace of both is set by the
// single read port of the slot memory: one entry per cycle.
// Reset: the fill count goes to zero, so no clearing pass over the memory is needed.
// Stalls: a finished result sits in the output register; the next item is taken
// meanwhile, and only its own result waits until that register frees up.
module earliest_deadline_timer_table_top #(
  parameter int unsigned SLOTS     = edtt_pkg::EDTT_SLOTS,
  parameter int unsigned TAG_BITS  = edtt_pkg::EDTT_TAG_BITS,
  parameter int unsigned TIME_BITS = edtt_pkg::EDTT_TIME_BITS,
  localparam int unsigned IN_W  =
    ((TIME_BITS + edtt_pkg::DELAY_W + TAG_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W =
    ((edtt_pkg::STATUS_W + TAG_BITS + TIME_BITS + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // now_us, delay_ms, tag
  input  logic [IN_W-1:0]               s_axis_tdata,
  // kind
  input  logic [edtt_pkg::KIND_W-1:0]   s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status, fired_tag, wait_us
  output logic [OUT_W-1:0]              m_axis_tdata
);
  import edtt_pkg::*;

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned SUM_W = ((TIME_BITS > SPAN_W) ? TIME_BITS : SPAN_W) + 1;
  localparam int unsigned OUT_PAD = OUT_W - STATUS_W - TAG_BITS - TIME_BITS;

  typedef struct packed {
    logic [TIME_BITS-1:0] dl;
    logic [TAG_BITS-1:0]  tag;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ADD, ST_SCAN, ST_DECIDE, ST_SHIFT, ST_RESP
  } state_e;

  // Slot memory: live timers packed at 0..cnt-1, oldest at 0, newest at cnt-1.
  entry_t mem [SLOTS];
  entry_t mem_rd_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa, mem_ra;
  entry_t           mem_wd;

  state_e               state_q, state_d;
  edtt_kind_e           kind_q, kind_d;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic [TAG_BITS-1:0]  tag_q, tag_d;
  logic [SPAN_W-1:0]    span_q, span_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CNT_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic                 rd_pend_q, rd_pend_d;
  logic [IDX_W-1:0]     chk_ptr_q, chk_ptr_d;
  logic [TIME_BITS-1:0] best_dl_q, best_dl_d;
  logic [TAG_BITS-1:0]  best_tag_q, best_tag_d;
  logic [IDX_W-1:0]     best_idx_q, best_idx_d;
  logic                 hit_q, hit_d;
  edtt_status_e         pend_status_q, pend_status_d;
  logic [TAG_BITS-1:0]  pend_fired_q, pend_fired_d;
  logic [TIME_BITS-1:0] pend_wait_q, pend_wait_d;
  logic                 out_valid_q, out_valid_d;
  edtt_status_e         out_status_q, out_status_d;
  logic [TAG_BITS-1:0]  out_fired_q, out_fired_d;
  logic [TIME_BITS-1:0] out_wait_q, out_wait_d;

  logic                 accept, issue, last_chk;
  logic [SUM_W-1:0]     dl_sum;
  logic [TIME_BITS-1:0] dl_sat;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign issue         = (rd_ptr_q < cnt_q);
  assign last_chk      = (CNT_W'(chk_ptr_q) == (cnt_q - CNT_W'(1)));

  // deadline = now + span, saturated at the largest time value
  assign dl_sum = SUM_W'(now_q) + SUM_W'(span_q);
  assign dl_sat = (|dl_sum[SUM_W-1:TIME_BITS]) ? {TIME_BITS{1'b1}}
                                               : dl_sum[TIME_BITS-1:0];

  always_comb begin
    state_d       = state_q;
    kind_d        = kind_q;
    now_d         = now_q;
    tag_d         = tag_q;
    span_d        = span_q;
    cnt_d         = cnt_q;
    rd_ptr_d      = rd_ptr_q;
    rd_pend_d     = rd_pend_q;
    chk_ptr_d     = chk_ptr_q;
    best_dl_d     = best_dl_q;
    best_tag_d    = best_tag_q;
    best_idx_d    = best_idx_q;
    hit_d         = hit_q;
    pend_status_d = pend_status_q;
    pend_fired_d  = pend_fired_q;
    pend_wait_d   = pend_wait_q;
    out_valid_d   = out_valid_q;
    out_status_d  = out_status_q;
    out_fired_d   = out_fired_q;
    out_wait_d    = out_wait_q;
    mem_we        = 1'b0;
    mem_wa        = chk_ptr_q - IDX_W'(1);
    mem_wd        = mem_rd_q;
    mem_ra        = rd_ptr_q[IDX_W-1:0];

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    // read issue shared by scan and compaction
    if (state_q == ST_SCAN || state_q == ST_SHIFT) begin
      rd_pend_d = issue;
      if (issue) begin
        rd_ptr_d  = rd_ptr_q + CNT_W'(1);
        chk_ptr_d = rd_ptr_q[IDX_W-1:0];
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          kind_d        = edtt_kind_e'(s_axis_tuser);
          now_d         = s_axis_tdata[TIME_BITS-1:0];
          span_d        = SPAN_W'(s_axis_tdata[TIME_BITS +: DELAY_W]) * SPAN_W'(US_PER_MS);
          tag_d         = s_axis_tdata[TIME_BITS+DELAY_W +: TAG_BITS];
          hit_d         = 1'b0;
          rd_ptr_d      = '0;
          rd_pend_d     = 1'b0;
          pend_status_d = STAT_NONE;
          pend_fired_d  = '0;
          pend_wait_d   = '0;
          case (edtt_kind_e'(s_axis_tuser))
            KIND_ADD: begin
              state_d = ST_ADD;
            end
            KIND_FIRE, KIND_REMOVE, KIND_FIND, KIND_QUERY: begin
              state_d = (cnt_q == '0) ? ST_RESP : ST_SCAN;
            end
            KIND_CLEAR: begin
              cnt_d         = '0;
              pend_status_d = STAT_OK;
              state_d       = ST_RESP;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_ADD: begin
        if (cnt_q == CNT_W'(SLOTS)) begin
          pend_status_d = STAT_FULL;
        end else begin
          mem_we        = 1'b1;
          mem_wa        = cnt_q[IDX_W-1:0];
          mem_wd        = '{dl: dl_sat, tag: tag_q};
          cnt_d         = cnt_q + CNT_W'(1);
          pend_status_d = STAT_OK;
        end
        state_d = ST_RESP;
      end
      ST_SCAN: begin
        if (rd_pend_q) begin
          if (kind_q == KIND_FIRE || kind_q == KIND_QUERY) begin
            // strict compare keeps the older entry on a tie
            if (chk_ptr_q == '0 || mem_rd_q.dl < best_dl_q) begin
              best_dl_d  = mem_rd_q.dl;
              best_tag_d = mem_rd_q.tag;
              best_idx_d = chk_ptr_q;
            end
          end else if (mem_rd_q.tag == tag_q) begin
            // last match in the scan is the newest one
            hit_d      = 1'b1;
            best_idx_d = chk_ptr_q;
          end
          if (last_chk) begin
            state_d = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        rd_ptr_d  = CNT_W'(best_idx_q) + CNT_W'(1);
        rd_pend_d = 1'b0;
        state_d   = ST_RESP;
        case (kind_q)
          KIND_FIRE: begin
            if (best_dl_q <= now_q) begin
              pend_status_d = STAT_OK;
              pend_fired_d  = best_tag_q;
              state_d       = ST_SHIFT;
            end
          end
          KIND_QUERY: begin
            pend_status_d = STAT_OK;
            pend_wait_d   = (best_dl_q >= now_q) ? (best_dl_q - now_q)
                                                 : TIME_BITS'(1);
          end
          KIND_REMOVE: begin
            if (hit_q) begin
              pend_status_d = STAT_OK;
              state_d       = ST_SHIFT;
            end
          end
          KIND_FIND: begin
            if (hit_q) begin
              pend_status_d = STAT_OK;
            end
          end
          default: begin
            state_d = ST_RESP;
          end
        endcase
      end
      ST_SHIFT: begin
        // entry j read last cycle moves down to j-1
        if (rd_pend_q) begin
          mem_we = 1'b1;
        end
        if (!issue && !rd_pend_q) begin
          cnt_d   = cnt_q - CNT_W'(1);
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_status_d = pend_status_q;
          out_fired_d  = pend_fired_q;
          out_wait_d   = pend_wait_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q        <= kind_d;
    now_q         <= now_d;
    tag_q         <= tag_d;
    span_q        <= span_d;
    rd_ptr_q      <= rd_ptr_d;
    chk_ptr_q     <= chk_ptr_d;
    best_dl_q     <= best_dl_d;
    best_tag_q    <= best_tag_d;
    best_idx_q    <= best_idx_d;
    hit_q         <= hit_d;
    pend_status_q <= pend_status_d;
    pend_fired_q  <= pend_fired_d;
    pend_wait_q   <= pend_wait_d;
    out_status_q  <= out_status_d;
    out_fired_q   <= out_fired_d;
    out_wait_q    <= out_wait_d;
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd_q <= mem[mem_ra];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_wait_q, out_fired_q, out_status_q};

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(SLOTS))
    else $error("fill count above slot count");

  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_ADD || state_q == ST_SHIFT))
    else $error("slot write outside add or compaction");

  a_shift_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q == ST_SHIFT) |-> (CNT_W'(mem_wa) < cnt_q - CNT_W'(1)))
    else $error("compaction writes past live range");

  a_chk_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_pend_q && (state_q == ST_SCAN || state_q == ST_SHIFT))
      |-> (CNT_W'(chk_ptr_q) < cnt_q))
    else $error("read of a slot beyond the fill count");

  a_cnt_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != cnt_d) |-> (state_q == ST_ADD || state_q == ST_SHIFT || accept))
    else $error("fill count moved outside add, compaction or clear");

endmodule

@@ sim/timer_table_scoreboard.sv @@
// Scoreboard package for the timer table: request types, response predictor and checker.
package timer_table_sb_pkg;
  import edtt_pkg::*;

  localparam int unsigned TAG_W    = EDTT_TAG_BITS;
  localparam int unsigned TIME_W   = EDTT_TIME_BITS;
  localparam int unsigned RESP_W   = ((STATUS_W + TAG_W + TIME_W + 7) / 8) * 8;
  localparam int unsigned FIRED_LO = STATUS_W;
  localparam int unsigned WAIT_LO  = STATUS_W + TAG_W;
  localparam int unsigned PAD_LO   = WAIT_LO + TIME_W;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // kind codes the block does not implement
  localparam logic [KIND_W-1:0] KIND_RSVD_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RSVD_7 = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [TIME_W-1:0]  now_us;
    logic [DELAY_W-1:0] delay_ms;
    logic [TAG_W-1:0]   tag;
  } timer_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    fired_tag;
    logic [TIME_W-1:0]   wait_us;
  } timer_resp_t;

  class timer_table_checker;
    // live timers, index 0 is the newest
    logic [TIME_W-1:0] deadline_q[$];
    logic [TAG_W-1:0]  tag_q[$];
    timer_resp_t       pending_results[$];
    int unsigned       mismatches;
    int unsigned       resp_seen;

    function int unsigned live_count();
      return deadline_q.size();
    endfunction

    // earliest deadline; the oldest entry wins a tie
    function int earliest_index();
      int best;
      best = 0;
      for (int i = 1; i < deadline_q.size(); i++)
        if (deadline_q[i] <= deadline_q[best]) best = i;
      return best;
    endfunction

    function int newest_with_tag(logic [TAG_W-1:0] t);
      foreach (tag_q[i])
        if (tag_q[i] == t) return i;
      return -1;
    endfunction

    function void drop_timer(int k);
      deadline_q.delete(k);
      tag_q.delete(k);
    endfunction

    // update the table for one accepted request and queue its response
    function void note_request(timer_req_t req);
      timer_resp_t       rsp;
      logic [63:0]       span;
      logic [TIME_W-1:0] headroom;
      logic [TIME_W-1:0] dl;
      int                k;
      rsp = '0;
      rsp.status = STAT_NONE;
      case (req.kind)
        KIND_ADD: begin
          if (live_count() >= EDTT_SLOTS) begin
            rsp.status = STAT_FULL;
          end else begin
            span     = 64'(req.delay_ms) * 64'(US_PER_MS);
            headroom = TIME_MAX - req.now_us;
            if (span > {16'b0, headroom}) dl = TIME_MAX;
            else dl = req.now_us + span[TIME_W-1:0];
            deadline_q.push_front(dl);
            tag_q.push_front(req.tag);
            rsp.status = STAT_OK;
          end
        end
        KIND_FIRE: begin
          if (live_count() > 0) begin
            k = earliest_index();
            if (deadline_q[k] <= req.now_us) begin
              rsp.fired_tag = tag_q[k];
              rsp.status    = STAT_OK;
              drop_timer(k);
            end
          end
        end
        KIND_REMOVE: begin
          k = newest_with_tag(req.tag);
          if (k >= 0) begin
            drop_timer(k);
            rsp.status = STAT_OK;
          end
        end
        KIND_FIND: begin
          if (newest_with_tag(req.tag) >= 0) rsp.status = STAT_OK;
        end
        KIND_QUERY: begin
          if (live_count() > 0) begin
            dl = deadline_q[earliest_index()];
            rsp.wait_us = (dl >= req.now_us) ? dl - req.now_us : TIME_W'(1);
            rsp.status  = STAT_OK;
          end
        end
        KIND_CLEAR: begin
          deadline_q.delete();
          tag_q.delete();
          rsp.status = STAT_OK;
        end
        default: ;
      endcase
      pending_results.push_back(rsp);
    endfunction

    task report_mismatch(string what, logic [RESP_W-1:0] got, logic [RESP_W-1:0] want);
      mismatches++;
      $display("response %0d: %s got %0h, expected %0h", resp_seen, what, got, want);
    endtask

    task check_response(logic [RESP_W-1:0] data);
      timer_resp_t want;
      resp_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", data, '0);
        return;
      end
      want = pending_results.pop_front();
      if (data[FIRED_LO-1:0] !== want.status)
        report_mismatch("status", RESP_W'(data[FIRED_LO-1:0]), RESP_W'(want.status));
      if (data[WAIT_LO-1:FIRED_LO] !== want.fired_tag)
        report_mismatch("fired_tag", RESP_W'(data[WAIT_LO-1:FIRED_LO]),
                        RESP_W'(want.fired_tag));
      if (data[PAD_LO-1:WAIT_LO] !== want.wait_us)
        report_mismatch("wait_us", RESP_W'(data[PAD_LO-1:WAIT_LO]), RESP_W'(want.wait_us));
      if (data[RESP_W-1:PAD_LO] !== '0)
        report_mismatch("padding", RESP_W'(data[RESP_W-1:PAD_LO]), '0);
    endtask
  endclass

endpackage

@@ sim/tb.sv @@
// Testbench top for the earliest-deadline timer table: stimulus, handshakes and checking.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import edtt_pkg::*;
  import timer_table_sb_pkg::*;

  localparam int unsigned CLK_PERIOD   = 20;
  localparam int unsigned IN_W         = ((TIME_W + DELAY_W + TAG_W + 7) / 8) * 8;
  localparam int unsigned ITEM_TARGET  = 1400;
  localparam int unsigned IDLE_PCT     = 18;
  // far above the time the slowest item takes, so only a hung block trips it
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 100;
  // window of items sent with both sides held busy
  localparam int unsigned CALM_FROM    = 500;
  localparam int unsigned CALM_TO      = 800;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata;   // now_us, delay_ms, tag (lowest bit up)
  logic [KIND_W-1:0] s_axis_tuser;   // kind
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [RESP_W-1:0] m_axis_tdata;   // status, fired_tag, wait_us, zero pad

  timer_table_checker tracker = new();

  bit                calm;        // no idling on either side while set
  int unsigned       sent;        // requests accepted, reserved kinds excluded
  int unsigned       quiet_cycles;
  logic [TIME_W-1:0] wall_us;     // running notion of "now" for the stimulus

  earliest_deadline_timer_table_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // ---------------------------------------------------------------------------
  // Random field helpers
  // ---------------------------------------------------------------------------
  function automatic logic [TIME_W-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TIME_W-1:0];
  endfunction

  // mostly a small pool so duplicates and hits are common
  function automatic logic [TAG_W-1:0] rand_tag();
    logic [31:0] r;
    r = $urandom;
    if ($urandom_range(99) < 70) return TAG_W'($urandom_range(0, 7));
    return r[TAG_W-1:0];
  endfunction

  // a tag that is likely live, for remove and find
  function automatic logic [TAG_W-1:0] probe_tag();
    if (tracker.live_count() > 0 && $urandom_range(99) < 60)
      return tracker.tag_q[$urandom_range(0, tracker.live_count() - 1)];
    return rand_tag();
  endfunction

  // short delays keep timers coming due; the odd full-range one can saturate when now is near the top
  function automatic logic [DELAY_W-1:0] rand_delay();
    case ($urandom_range(0, 9))
      8:       return DELAY_W'($urandom_range(0, 1000));
      9:       return $urandom;
      default: return DELAY_W'($urandom_range(0, 5));
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] next_now();
    if ($urandom_range(99) < 4) wall_us = rand_time();
    else wall_us = wall_us + TIME_W'($urandom_range(0, 2500));
    return wall_us;
  endfunction

  // ---------------------------------------------------------------------------
  // Source: present one item, hold it until accepted, then note it
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] now_us,
                              input logic [DELAY_W-1:0] delay_ms,
                              input logic [TAG_W-1:0] tag);
    timer_req_t req;
    req = '{kind: kind, now_us: now_us, delay_ms: delay_ms, tag: tag};
    @(negedge clk_i);
    while (idle_now()) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {tag, delay_ms, now_us};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_request(req);
    if (kind <= KIND_CLEAR) sent++;
  endtask

  task automatic send_random_op();
    int unsigned w;
    w = $urandom_range(0, 99);
    if (w < 35)      send_request(KIND_ADD, next_now(), rand_delay(), rand_tag());
    else if (w < 55) send_request(KIND_FIRE, next_now(), $urandom, rand_tag());
    else if (w < 67) send_request(KIND_REMOVE, next_now(), $urandom, probe_tag());
    else if (w < 79) send_request(KIND_FIND, next_now(), $urandom, probe_tag());
    else if (w < 93) send_request(KIND_QUERY, next_now(), $urandom, rand_tag());
    else if (w < 96) send_request(KIND_CLEAR, next_now(), $urandom, rand_tag());
    else send_request(($urandom_range(0, 1) != 0) ? KIND_RSVD_7 : KIND_RSVD_6,
                      next_now(), $urandom, rand_tag());
  endtask

  // ---------------------------------------------------------------------------
  // Sink: random back-pressure, responses checked at the accepting edge
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) m_axis_tready <= !idle_now();

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.check_response(m_axis_tdata);
  end

  // watchdog: too long without any handshake means the block hung
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    calm          = 1'b0;
    sent          = 0;
    quiet_cycles  = 0;
    wall_us       = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // empty table: every lookup misses, reserved kinds do nothing
    send_request(KIND_QUERY,  '0, '0, '0);
    send_request(KIND_FIRE,   '0, '0, '0);
    send_request(KIND_REMOVE, '0, '0, 16'h0005);
    send_request(KIND_FIND,   '0, '0, 16'h0005);
    send_request(KIND_RSVD_6, '0, '0, '0);
    send_request(KIND_RSVD_7, TIME_MAX, '1, '1);
    send_request(KIND_CLEAR,  '0, '0, '0);
    // zero deadline, then the largest delay at the top of time saturates
    send_request(KIND_ADD, '0, '0, 16'h0000);
    send_request(KIND_ADD, TIME_MAX, '1, 16'hFFFF);
    // duplicate tags with deadlines 1000 and 2000
    send_request(KIND_ADD, TIME_W'(1000), '0, 16'h1234);
    send_request(KIND_ADD, TIME_W'(1000), DELAY_W'(1), 16'h1234);
    send_request(KIND_FIND, TIME_W'(1000), '0, 16'h1234);
    send_request(KIND_FIND, TIME_W'(1000), '0, 16'h4321);
    // wait of zero when the deadline is now, one when it is past
    send_request(KIND_QUERY, '0, '0, '0);
    send_request(KIND_QUERY, TIME_W'(500), '0, '0);
    send_request(KIND_FIRE, '0, '0, '0);
    // tie at 1000: the older 0x1234 entry must fire first
    send_request(KIND_ADD, TIME_W'(1000), '0, 16'h0007);
    send_request(KIND_FIRE, TIME_W'(1500), '0, '0);
    // remove takes the one 0x1234 entry still live, the one due at 2000
    send_request(KIND_REMOVE, TIME_W'(1500), '0, 16'h1234);
    // one microsecond early: nothing due, wait of one
    send_request(KIND_FIRE, TIME_W'(999), '0, '0);
    send_request(KIND_QUERY, TIME_W'(999), '0, '0);
    // add just past and exactly at the saturation point
    send_request(KIND_ADD, TIME_MAX - TIME_W'(999), DELAY_W'(1), 16'hAAAA);
    send_request(KIND_ADD, TIME_MAX - TIME_W'(1000), DELAY_W'(1), 16'h5555);
    send_request(KIND_FIRE, TIME_MAX, '0, '0);
    send_request(KIND_CLEAR, '0, '0, '0);
    send_request(KIND_QUERY, '0, '0, '0);

    // random bursts
    while (sent < ITEM_TARGET) begin
      calm = (sent >= CALM_FROM) && (sent < CALM_TO);
      case ($urandom_range(0, 9))
        0, 1: begin
          // fill to the brim, then knock on a full table
          while (tracker.live_count() < EDTT_SLOTS)
            send_request(KIND_ADD, next_now(), rand_delay(), rand_tag());
          repeat ($urandom_range(1, 3))
            send_request(KIND_ADD, next_now(), rand_delay(), rand_tag());
        end
        7, 8: begin
          // jump ahead and fire once more than there are live timers, to try to run the table dry
          wall_us = wall_us + TIME_W'($urandom_range(0, 50000));
          repeat (tracker.live_count() + 1) begin
            if ($urandom_range(0, 4) == 0) send_request(KIND_FIRE, TIME_MAX, $urandom, '0);
            else send_request(KIND_FIRE, next_now(), $urandom, rand_tag());
          end
        end
        9: begin
          // noise over the full range of every field
          repeat (10)
            send_request(KIND_W'($urandom_range(0, 7)), rand_time(), $urandom,
                         TAG_W'($urandom_range(0, 65535)));
        end
        default: begin
          repeat (20) send_random_op();
        end
      endcase
    end
    calm = 1'b0;
    @(negedge clk_i) s_axis_tvalid <= 1'b0;

    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/edtt_pkg.sv
rtl/core/earliest_deadline_timer_table_top.sv
sim/timer_table_scoreboard.sv
sim/tb.sv
